@@ hdl/psra_pkg.sv @@
// Package: payload types, fixed-point widths and CORDIC constants for the radiance adjust block.
package psra_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CwW = 33;   // CORDIC x/y/z width, Q1.30 plus headroom
  localparam logic signed [CwW-1:0] CordicGain = 33'sd652032874;

  typedef struct packed {
    logic signed [31:0] radiance;
    logic signed [31:0] stokes_q;
    logic signed [31:0] stokes_u;
    logic        [15:0] sensitivity;
    logic        [15:0] peak_angle;
    logic signed [15:0] plane_offset;
    logic               geo_valid;
  } in_t;

  typedef struct packed {
    logic signed [31:0] measured_radiance;
    logic               adjusted;
  } out_t;

  // Arc tangent of 2^-i in 2^-32 circle units
  function automatic logic signed [CwW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [CwW-1:0] r;
    case (idx)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/polarization_sensitivity_radiance_adjust.sv @@
// Top level: pipelined polarization sensitivity adjustment of one spectral sample per cycle.
//
// Usage: samples enter on the in channel (in_valid_i/in_ready_o, payload in_data_i)
// and leave on the out channel (out_valid_o/out_ready_i, payload out_data_o), one
// result transaction per input transaction, in order.
// Each sample gets measured = I + 2*sens*(Q*cos(phi) - U*sin(phi)), with phi the
// difference of plane offset and peak angle, saturated to 32 bits. Samples with
// radiance <= 0 or no geolocation pass through unchanged with adjusted = 0.
// Pipeline: 35 register stages, namely one input stage, 30 CORDIC rotation
// stages (one iteration each), a product stage, a subtract/round stage, a
// sensitivity product stage and the add/saturate output register.
// Throughput: one sample per cycle; the CORDIC stage chain sets the latency.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// Stall: when a result waits and out_ready_i is low, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated. A waiting result does not block
// acceptance when the pipeline moves on as the receiver takes it.
module polarization_sensitivity_radiance_adjust (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psra_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psra_pkg::out_t      out_data_o
);
  import psra_pkg::*;

  localparam int unsigned NStg = CordicSteps + 5;

  typedef struct packed {
    logic signed [31:0] rad;
    logic signed [31:0] q;
    logic signed [31:0] u;
    logic        [15:0] sens;
    logic        [1:0]  quad;
    logic               apply;
  } side_t;

  logic                  adv;
  logic [NStg-1:0]       vld_q;
  side_t                 sd_q [0:CordicSteps];
  logic signed [CwW-1:0] x_q  [0:CordicSteps];
  logic signed [CwW-1:0] y_q  [0:CordicSteps];
  logic signed [CwW-1:0] z_q  [0:CordicSteps];
  logic [15:0]           p_d;

  // Global advance: the pipeline moves unless a result is stuck at the output
  assign adv        = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = adv;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // Input stage: angle difference and CORDIC seed
  assign p_d = in_data_i.plane_offset - in_data_i.peak_angle;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0].rad   <= in_data_i.radiance;
      sd_q[0].q     <= in_data_i.stokes_q;
      sd_q[0].u     <= in_data_i.stokes_u;
      sd_q[0].sens  <= in_data_i.sensitivity;
      sd_q[0].quad  <= p_d[15:14];
      sd_q[0].apply <= (in_data_i.radiance > 32'sd0) && in_data_i.geo_valid;
      x_q[0]        <= CordicGain;
      y_q[0]        <= '0;
      z_q[0]        <= $signed({3'b000, p_d[13:0], 16'h0000});
    end
  end

  // CORDIC rotation stages, one iteration per register stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    localparam logic [4:0] Idx = 5'(i);
    logic signed [CwW-1:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = atan_lut(Idx);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q[i+1] <= sd_q[i];
        if (!z_q[i][CwW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  // Quadrant fold and Stokes products
  side_t                 sm_q, st_q, sp_q;
  logic signed [CwW-1:0] c_d, s_d;
  logic signed [64:0]    pq_q, pu_q;
  localparam int unsigned Ce = CordicSteps;

  always_comb begin
    case (sd_q[Ce].quad)
      2'd0: begin c_d = x_q[Ce];  s_d = y_q[Ce];  end
      2'd1: begin c_d = -y_q[Ce]; s_d = x_q[Ce];  end
      2'd2: begin c_d = -x_q[Ce]; s_d = -y_q[Ce]; end
      default: begin c_d = y_q[Ce]; s_d = -x_q[Ce]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_q <= sd_q[Ce];
      pq_q <= 65'(sd_q[Ce].q * c_d);
      pu_q <= 65'(sd_q[Ce].u * s_d);
    end
  end

  // Difference and round to the sensitivity scale
  logic signed [65:0] t_d;
  logic signed [36:0] t1_q;
  assign t_d = 66'(pq_q) - 66'(pu_q) + 66'sd268435456;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= sm_q;
      t1_q <= t_d[65:29];
    end
  end

  // Sensitivity product
  logic signed [53:0] sp_prod_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_q      <= st_q;
      sp_prod_q <= 54'($signed({1'b0, st_q.sens}) * t1_q);
    end
  end

  // Round, add, saturate, output register
  logic signed [53:0] rnd_d;
  logic signed [38:0] m_d;
  logic signed [31:0] sat_d;
  out_t               out_q;

  assign rnd_d = sp_prod_q + 54'sd32768;
  assign m_d   = 39'(sp_q.rad) + 39'($signed(rnd_d[53:16]));

  always_comb begin
    if (m_d > 39'sd2147483647) begin
      sat_d = 32'sh7fffffff;
    end else if (m_d < -39'sd2147483648) begin
      sat_d = 32'sh80000000;
    end else begin
      sat_d = m_d[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.measured_radiance <= sp_q.apply ? sat_d : sp_q.rad;
      out_q.adjusted          <= sp_q.apply;
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign out_data_o  = out_q;

  // Ready follows the output stall exactly
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not match output stall");

  // A stalled pipeline keeps every valid bit in place
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

  // A bypassed result carries the input radiance untouched
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[NStg-2] && !sp_q.apply) |=> (out_data_o.measured_radiance == $past(sp_q.rad)))
    else $error("pass-through sample was modified");

endmodule
